// File: hw/rtl/bounded_repeat_random_picker_defines.svh
// Assertion macros shared by the picker's RTL files.
// Each macro takes a label, a clock, a synchronous reset, an antecedent and a consequent.
`ifndef BOUNDED_REPEAT_RANDOM_PICKER_DEFINES_SVH
`define BOUNDED_REPEAT_RANDOM_PICKER_DEFINES_SVH

`ifndef SYNTHESIS
`define BRP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("picker check failed in the same cycle");
`define BRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("picker check failed in the following cycle");
`else
`define BRP_ASSERT_SAME(label, clk, rst, ante, cons)
`define BRP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: hw/rtl/brp_pkg.sv
`default_nettype none

package brp_pkg;

   // Storage sizing.
   localparam int MAX_SLOTS  = 256;
   localparam int COUNT_BITS = 8;
   localparam int SLOT_BITS  = $clog2(MAX_SLOTS);

   // Field widths.
   localparam int WORD_BITS  = 16;
   localparam int LOW_BITS   = 16;
   localparam int SIZE_BITS  = 9;
   localparam int LIMIT_BITS = 8;
   localparam int VALUE_BITS = 17;
   localparam int INDEX_BITS = 2;
   localparam int DATA_BITS  = 16;
   localparam int DIV_BITS   = $clog2(WORD_BITS);

   // Smallest usable range size.
   localparam int MIN_SIZE = 2;

   // Register indexes.
   localparam logic [INDEX_BITS-1:0] CSR_RANGE_LOW   = 2'd0;
   localparam logic [INDEX_BITS-1:0] CSR_RANGE_SIZE  = 2'd1;
   localparam logic [INDEX_BITS-1:0] CSR_MAX_REPEATS = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SEEK,
      ST_EMIT,
      ST_READ,
      ST_CHECK
   } brp_state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic seek_init;
      logic advance;
      logic bump;
      logic emit_pick;
      logic emit_exh;
   } brp_cmd_type;

   typedef struct packed {
      logic div_last;
      logic unlimited;
      logic fits;
      logic last;
   } brp_stat_type;

endpackage

`default_nettype wire

// File: hw/rtl/brp_ctrl.sv
`default_nettype none

`include "bounded_repeat_random_picker_defines.svh"

module brp_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output      logic                  busy,
   input  wire brp_pkg::brp_stat_type stat,
   output      brp_pkg::brp_cmd_type  cmd
);

   brp_pkg::brp_state_type state_ff;
   brp_pkg::brp_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         brp_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = brp_pkg::ST_DIV;
            end
         end
         brp_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = brp_pkg::ST_SEEK;
            end
         end
         brp_pkg::ST_SEEK: begin
            cmd.seek_init = 1'b1;
            state_in = stat.unlimited ? brp_pkg::ST_EMIT : brp_pkg::ST_READ;
         end
         brp_pkg::ST_EMIT: begin
            cmd.emit_pick = 1'b1;
            state_in = brp_pkg::ST_IDLE;
         end
         brp_pkg::ST_READ: begin
            // The count memory returns the current slot at the end of this cycle.
            state_in = brp_pkg::ST_CHECK;
         end
         brp_pkg::ST_CHECK: begin
            priority if (stat.fits) begin
               cmd.bump      = 1'b1;
               cmd.emit_pick = 1'b1;
               state_in      = brp_pkg::ST_IDLE;
            end else if (stat.last) begin
               cmd.emit_exh = 1'b1;
               state_in     = brp_pkg::ST_IDLE;
            end else begin
               cmd.advance = 1'b1;
               state_in    = brp_pkg::ST_READ;
            end
         end
         default: begin
            state_in = brp_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != brp_pkg::ST_IDLE);

   `BRP_ASSERT_NEXT(a_start_enters_div, clock, reset, start && !busy,
      state_ff == brp_pkg::ST_DIV)
   `BRP_ASSERT_NEXT(a_div_holds, clock, reset,
      (state_ff == brp_pkg::ST_DIV) && !stat.div_last, state_ff == brp_pkg::ST_DIV)
   `BRP_ASSERT_SAME(a_one_result_kind, clock, reset, cmd.emit_pick || cmd.emit_exh,
      !(cmd.emit_pick && cmd.emit_exh))

endmodule

`default_nettype wire

// File: hw/rtl/brp_dpath.sv
`default_nettype none

`include "bounded_repeat_random_picker_defines.svh"

module brp_dpath (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire brp_pkg::brp_cmd_type                   cmd,
   output      brp_pkg::brp_stat_type                  stat,
   input  wire logic [brp_pkg::WORD_BITS-1:0]          req_random_word,
   input  wire logic                                   req_search_up,
   input  wire logic                                   csr_write_enable,
   input  wire logic [brp_pkg::INDEX_BITS-1:0]         csr_index,
   input  wire logic [brp_pkg::DATA_BITS-1:0]          csr_write_data,
   output      logic                                   rsp_valid,
   output      logic signed [brp_pkg::VALUE_BITS-1:0]  rsp_picked_value,
   output      logic                                   rsp_exhausted
);

   // Configuration registers.
   logic [brp_pkg::LOW_BITS-1:0]   range_low_ff;
   logic [brp_pkg::SIZE_BITS-1:0]  range_size_ff;
   logic [brp_pkg::LIMIT_BITS-1:0] max_repeats_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff   <= '0;
         range_size_ff  <= brp_pkg::SIZE_BITS'(brp_pkg::MIN_SIZE);
         max_repeats_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            brp_pkg::CSR_RANGE_LOW:   range_low_ff   <= csr_write_data[brp_pkg::LOW_BITS-1:0];
            brp_pkg::CSR_RANGE_SIZE:  range_size_ff  <= csr_write_data[brp_pkg::SIZE_BITS-1:0];
            brp_pkg::CSR_MAX_REPEATS: max_repeats_ff <= csr_write_data[brp_pkg::LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Effective size, clamped between MIN_SIZE and the storage.
   logic [brp_pkg::SIZE_BITS-1:0] esize;
   logic [brp_pkg::SIZE_BITS-1:0] esize_m1;

   always_comb begin
      priority if (range_size_ff < brp_pkg::SIZE_BITS'(brp_pkg::MIN_SIZE)) begin
         esize = brp_pkg::SIZE_BITS'(brp_pkg::MIN_SIZE);
      end else if (range_size_ff > brp_pkg::SIZE_BITS'(brp_pkg::MAX_SLOTS)) begin
         esize = brp_pkg::SIZE_BITS'(brp_pkg::MAX_SLOTS);
      end else begin
         esize = range_size_ff;
      end
      esize_m1 = esize - brp_pkg::SIZE_BITS'(1);
   end

   // Restoring remainder unit, one dividend bit per cycle.
   logic [brp_pkg::WORD_BITS-1:0] word_ff;
   logic [brp_pkg::SLOT_BITS-1:0] rem_ff;
   logic [brp_pkg::DIV_BITS-1:0]  div_cnt_ff;
   logic                          up_ff;
   logic [brp_pkg::SIZE_BITS-1:0] trial;
   logic [brp_pkg::SIZE_BITS-1:0] trial_sub;

   assign trial     = {rem_ff, word_ff[brp_pkg::WORD_BITS-1]};
   assign trial_sub = trial - esize;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         word_ff    <= req_random_word;
         rem_ff     <= '0;
         div_cnt_ff <= '0;
         up_ff      <= req_search_up;
      end else if (cmd.div_step) begin
         word_ff    <= {word_ff[brp_pkg::WORD_BITS-2:0], 1'b0};
         rem_ff     <= (trial >= esize) ? trial_sub[brp_pkg::SLOT_BITS-1:0]
                                        : trial[brp_pkg::SLOT_BITS-1:0];
         div_cnt_ff <= div_cnt_ff + brp_pkg::DIV_BITS'(1);
      end
   end

   // Slot walker.
   logic [brp_pkg::SLOT_BITS-1:0] slot_ff;
   logic [brp_pkg::SLOT_BITS-1:0] steps_ff;
   logic [brp_pkg::SIZE_BITS-1:0] slot_up;
   logic [brp_pkg::SLOT_BITS-1:0] slot_next;

   assign slot_up = {1'b0, slot_ff} + brp_pkg::SIZE_BITS'(1);

   always_comb begin
      if (up_ff) begin
         slot_next = (slot_up >= esize) ? '0 : slot_up[brp_pkg::SLOT_BITS-1:0];
      end else begin
         slot_next = (slot_ff == '0) ? esize_m1[brp_pkg::SLOT_BITS-1:0]
                                     : slot_ff - brp_pkg::SLOT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.seek_init) begin
         slot_ff  <= rem_ff;
         steps_ff <= '0;
      end else if (cmd.advance) begin
         slot_ff  <= slot_next;
         steps_ff <= steps_ff + brp_pkg::SLOT_BITS'(1);
      end
   end

   // Use counts: one memory word per slot, with a valid flag per slot so that
   // reset clears all counts at once.
   logic [brp_pkg::COUNT_BITS-1:0] count_mem [brp_pkg::MAX_SLOTS];
   logic [brp_pkg::MAX_SLOTS-1:0]  valid_ff;
   logic [brp_pkg::COUNT_BITS-1:0] rd_q_ff;
   logic                           rd_valid_ff;
   logic [brp_pkg::COUNT_BITS-1:0] cur_count;
   logic [brp_pkg::COUNT_BITS-1:0] count_inc;

   assign cur_count = rd_valid_ff ? rd_q_ff : '0;
   assign count_inc = cur_count + brp_pkg::COUNT_BITS'(1);

   always_ff @(posedge clock) begin
      if (cmd.bump) begin
         count_mem[slot_ff] <= count_inc;
      end
      rd_q_ff <= count_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.bump) begin
            valid_ff[slot_ff] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[slot_ff];
      end
   end

   // Status toward the controller.
   always_comb begin
      stat.div_last  = (div_cnt_ff == brp_pkg::DIV_BITS'(brp_pkg::WORD_BITS - 1));
      stat.unlimited = (max_repeats_ff == '0);
      stat.fits      = (brp_pkg::LIMIT_BITS'(cur_count) < max_repeats_ff);
      stat.last      = ({1'b0, steps_ff} == esize_m1);
   end

   // Result register.
   logic                                 rsp_valid_ff;
   logic [brp_pkg::VALUE_BITS-1:0]       value_ff;
   logic                                 exh_ff;
   logic [brp_pkg::VALUE_BITS-1:0]       value_sum;

   assign value_sum = {range_low_ff[brp_pkg::LOW_BITS-1], range_low_ff}
                    + {{(brp_pkg::VALUE_BITS - brp_pkg::SLOT_BITS){1'b0}}, slot_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit_pick || cmd.emit_exh;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_pick) begin
         value_ff <= value_sum;
         exh_ff   <= 1'b0;
      end else if (cmd.emit_exh) begin
         value_ff <= '0;
         exh_ff   <= 1'b1;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_picked_value = $signed(value_ff);
   assign rsp_exhausted    = exh_ff;

   `BRP_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid_ff, !rsp_valid_ff)
   `BRP_ASSERT_SAME(a_exhausted_zero, clock, reset, rsp_valid_ff && exh_ff, value_ff == '0)
   `BRP_ASSERT_SAME(a_bump_below_limit, clock, reset, cmd.bump,
      (max_repeats_ff != '0) && (brp_pkg::LIMIT_BITS'(cur_count) < max_repeats_ff))

endmodule

`default_nettype wire

// File: hw/rtl/bounded_repeat_random_picker.sv
// Bounded-repeat random picker.
// Request beat: pulse start while busy is low, with req_random_word and req_search_up.
// The start slot is the word modulo the range size, clamped to 2..256; with a nonzero repeat limit the
// block walks up or down from there, with wraparound, to the first slot still under
// the limit, returns range_low plus that slot and counts one more use of it.
// Response beat: rsp_valid is high for exactly one cycle with rsp_picked_value and
// rsp_exhausted; the receiver cannot hold it off, so it must take every beat.
// Sequence: the remainder unit shifts in the word one dividend bit at a time, then the
// walker is loaded. With an unlimited limit the start slot is emitted directly; otherwise
// each examined slot takes a registered count-memory read, then the compare, until a
// slot fits or every slot of the range has been examined.
// One request is in flight at a time; busy stays high until the result is registered,
// and a new request may be taken while that result is being shown.
// Configuration: csr_write_enable writes range_low, range_size or max_repeats at
// csr_index 0, 1, 2; other indexes are ignored. Write only while busy is low.
// Reset is synchronous: it clears all use counts at once through per-slot valid
// flags, restores the registers to 0, 2, 0 and drops any pending response.
`default_nettype none

module bounded_repeat_random_picker (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output      logic                                   busy,
   input  wire logic [brp_pkg::WORD_BITS-1:0]          req_random_word,
   input  wire logic                                   req_search_up,
   output      logic                                   rsp_valid,
   output      logic signed [brp_pkg::VALUE_BITS-1:0]  rsp_picked_value,
   output      logic                                   rsp_exhausted,
   input  wire logic                                   csr_write_enable,
   input  wire logic [brp_pkg::INDEX_BITS-1:0]         csr_index,
   input  wire logic [brp_pkg::DATA_BITS-1:0]          csr_write_data
);

   // Commands from the sequencer and status back from the datapath.
   brp_pkg::brp_cmd_type  cmd;
   brp_pkg::brp_stat_type stat;

   // The sequencer steps the remainder unit, then, with a nonzero limit, the slot walk, one slot per
   // read-and-compare pair, and decides when a result beat is issued.
   brp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // The datapath holds the configuration, the remainder unit, the walker,
   // the use-count memory and the result register.
   brp_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_random_word  (req_random_word),
      .req_search_up    (req_search_up),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_picked_value (rsp_picked_value),
      .rsp_exhausted    (rsp_exhausted)
   );

endmodule

`default_nettype wire
